@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the directory entry decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define FD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/fatdir_pkg.sv @@
// Types, constants and helper functions for the FAT32 directory entry decoder.
`timescale 1ns / 1ps

package fatdir_pkg;

	localparam int BYTE_W    = 8;
	localparam int NAME_LEN  = 11;
	localparam int BASE_LEN  = 8;
	localparam int EXT_LEN   = 3;
	localparam int MAX_CHARS = 12;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 4;

	// Byte positions inside a 32-byte short entry.
	localparam logic [POS_W-1:0] POS_NAME_FIRST = 5'd0;
	localparam logic [POS_W-1:0] POS_NAME_LAST  = 5'd10;
	localparam logic [POS_W-1:0] POS_ATTR       = 5'd11;
	localparam logic [POS_W-1:0] POS_CASE       = 5'd12;
	localparam logic [POS_W-1:0] POS_CLUS_HI0   = 5'd20;
	localparam logic [POS_W-1:0] POS_CLUS_HI1   = 5'd21;
	localparam logic [POS_W-1:0] POS_CLUS_LO0   = 5'd26;
	localparam logic [POS_W-1:0] POS_CLUS_LO1   = 5'd27;
	localparam logic [POS_W-1:0] POS_SIZE0      = 5'd28;
	localparam logic [POS_W-1:0] POS_SIZE1      = 5'd29;
	localparam logic [POS_W-1:0] POS_SIZE2      = 5'd30;
	localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

	localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_DELETED = 8'hE5;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_LO = 8'h40;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_HI = 8'h5B;
	localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

	// Attribute bits.
	localparam int ATTR_HIDDEN_BIT = 1;
	localparam int ATTR_VOLUME_BIT = 3;
	localparam int ATTR_DIR_BIT    = 4;
	localparam logic [3:0] ATTR_LFN_NIBBLE = 4'hF;

	// Case flag bits in the reserved byte.
	localparam int CASE_BASE_SRC_BIT = 3;
	localparam int CASE_EXT_SRC_BIT  = 4;

	typedef logic [NAME_LEN-1:0][BYTE_W-1:0]  name_t;
	typedef logic [MAX_CHARS-1:0][BYTE_W-1:0] chars_t;

	typedef struct packed {
		logic               emit;
		logic               eod;
		logic [CNT_W-1:0]   count;
		chars_t             chars;
	} fmt_t;

	function automatic logic [BYTE_W-1:0] fold_char(input logic [BYTE_W-1:0] c,
		input logic lower);
		logic [BYTE_W-1:0] r;
		r = c;
		if (lower && c > CHAR_UPPER_LO && c < CHAR_UPPER_HI)
			r = c + CASE_OFFSET;
		return r;
	endfunction

endpackage

@@ hw/rtl/fatdir_name_fmt.sv @@
// Entry classification and 8.3 name formatting for one stored short entry.
`timescale 1ns / 1ps

module fatdir_name_fmt import fatdir_pkg::*; (
	input  name_t             name,
	input  logic [BYTE_W-1:0] attr,
	input  logic [1:0]        case_flags,
	input  logic              show_hidden,
	output fmt_t              fmt
);

	logic [2:0]       base_end;
	logic [1:0]       ext_len;
	logic             has_ext;
	logic [CNT_W-1:0] base_len;
	logic             pass;

	always_comb begin
		base_end = '0;
		for (int i = 0; i < BASE_LEN; i++) begin
			if (name[i] != CHAR_SPACE)
				base_end = 3'(i);
		end
		ext_len = '0;
		for (int j = 0; j < EXT_LEN; j++) begin
			if (name[BASE_LEN + j] != CHAR_SPACE)
				ext_len = 2'(j + 1);
		end
	end

	assign has_ext  = !attr[ATTR_DIR_BIT] && (ext_len != 2'd0);
	assign base_len = {1'b0, base_end} + 4'd1;

	assign pass = (name[0] != CHAR_DELETED)
		&& (attr[3:0] != ATTR_LFN_NIBBLE)
		&& !attr[ATTR_VOLUME_BIT]
		&& (!attr[ATTR_HIDDEN_BIT] || show_hidden);

	always_comb begin
		fmt.eod  = (name[0] == CHAR_ZERO);
		fmt.emit = fmt.eod || pass;
		if (fmt.eod)
			fmt.count = 4'd1;
		else if (has_ext)
			fmt.count = base_len + 4'd1 + {2'b00, ext_len};
		else
			fmt.count = base_len;

		fmt.chars = '0;
		if (!fmt.eod) begin
			for (int k = 0; k < BASE_LEN; k++) begin
				if (4'(k) < base_len)
					fmt.chars[k] = fold_char(name[k], case_flags[0]);
			end
			// The dot and the extension sit right after the trimmed base name.
			for (int k = 1; k < MAX_CHARS; k++) begin
				if (has_ext && 4'(k) == base_len)
					fmt.chars[k] = CHAR_DOT;
				for (int j = 0; j < EXT_LEN; j++) begin
					if (has_ext && 2'(j) < ext_len && 4'(k) == base_len + 4'(j + 1))
						fmt.chars[k] = fold_char(name[BASE_LEN + j], case_flags[1]);
				end
			end
		end
	end

endmodule

@@ hw/rtl/fat32_dir_entry_decoder_unit.sv @@
// The first result of an entry is valid in the cycle after its last byte is taken.
// Throughput: one input byte per cycle; results leave a 12-deep shift buffer one per cycle while out_ready is high.
// Input stalls only on an entry's last byte while the previous entry's results are pending.
// Reset (arst_n low, asynchronous) clears byte position, show_hidden and the result valid flag and count.
// Entry field stores are not reset; every field is written before the entry completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fat32_dir_entry_decoder_unit import fatdir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              show_hidden,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              entry_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] name_char,
	output logic              char_last,
	output logic              end_of_dir,
	output logic              is_directory,
	output logic [31:0]       first_cluster,
	output logic [31:0]       file_size,
	output logic [BYTE_W-1:0] attributes
);

	logic              show_hidden_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_eff;
	name_t             name_q;
	logic [BYTE_W-1:0] attr_q;
	logic [1:0]        case_q;
	logic [31:0]       clus_q;
	logic [23:0]       size_q;

	chars_t            chars_q;
	logic [CNT_W-1:0]  rem_q;
	logic              out_valid_q;
	logic              eod_q;
	logic              dir_q;
	logic [31:0]       clus_out_q;
	logic [31:0]       size_out_q;
	logic [BYTE_W-1:0] attr_out_q;

	fmt_t              fmt;
	logic              in_fire;
	logic              pop;
	logic              buf_hold;
	logic              load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			show_hidden_q <= 1'b0;
		else if (cfg_valid)
			show_hidden_q <= show_hidden;
	end

	assign pos_eff  = entry_start ? POS_NAME_FIRST : pos_q;
	assign pop      = out_valid_q && out_ready;
	// The buffer is busy while it holds results, unless its final result leaves this cycle.
	assign buf_hold = out_valid_q && !(out_ready && char_last);
	assign in_ready = (pos_eff != POS_LAST) || !buf_hold;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (in_fire)
			pos_q <= pos_eff + 5'd1;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			case (pos_eff) inside
				[POS_NAME_FIRST:POS_NAME_LAST]: name_q[4'(pos_eff)] <= data_byte;
				POS_ATTR:     attr_q        <= data_byte;
				POS_CASE:     case_q        <= {data_byte[CASE_EXT_SRC_BIT],
					data_byte[CASE_BASE_SRC_BIT]};
				POS_CLUS_HI0: clus_q[23:16] <= data_byte;
				POS_CLUS_HI1: clus_q[31:24] <= data_byte;
				POS_CLUS_LO0: clus_q[7:0]   <= data_byte;
				POS_CLUS_LO1: clus_q[15:8]  <= data_byte;
				POS_SIZE0:    size_q[7:0]   <= data_byte;
				POS_SIZE1:    size_q[15:8]  <= data_byte;
				POS_SIZE2:    size_q[23:16] <= data_byte;
				default: ;
			endcase
		end
	end

	fatdir_name_fmt u_fmt (
		.name        (name_q),
		.attr        (attr_q),
		.case_flags  (case_q),
		.show_hidden (show_hidden_q),
		.fmt         (fmt)
	);

	assign load = in_fire && (pos_eff == POS_LAST) && fmt.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			rem_q       <= fmt.count;
		end else if (pop) begin
			out_valid_q <= (rem_q != 4'd1);
			rem_q       <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q    <= fmt.chars;
			eod_q      <= fmt.eod;
			dir_q      <= fmt.eod ? 1'b0 : attr_q[ATTR_DIR_BIT];
			clus_out_q <= fmt.eod ? 32'd0 : clus_q;
			size_out_q <= fmt.eod ? 32'd0 : {data_byte, size_q};
			attr_out_q <= fmt.eod ? CHAR_ZERO : attr_q;
		end else if (pop) begin
			chars_q <= {CHAR_ZERO, chars_q[MAX_CHARS-1:1]};
		end
	end

	assign out_valid     = out_valid_q;
	assign name_char     = chars_q[0];
	assign char_last     = (rem_q == 4'd1);
	assign end_of_dir    = eod_q;
	assign is_directory  = dir_q;
	assign first_cluster = clus_out_q;
	assign file_size     = size_out_q;
	assign attributes    = attr_out_q;

	`FD_ASSERT(a_rem_range, out_valid |-> (rem_q != 4'd0 && rem_q <= 4'(MAX_CHARS)),
		"result count out of range")
	`FD_ASSERT(a_eod_single, (out_valid && end_of_dir) |-> (char_last && name_char == CHAR_ZERO
		&& first_cluster == 32'd0 && file_size == 32'd0), "bad end of directory result")
	`FD_ASSERT(a_more_follow, (out_valid && out_ready && !char_last) |=> out_valid,
		"entry results cut short")
	`FD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!out_valid && pos_q == POS_NAME_FIRST),
		"state not cleared in reset")

endmodule

@@ sim/fat32_dir_entry_decoder_checker.sv @@
// Scoreboard for the directory entry decoder: predicts each name character result and checks it.
`timescale 1ns / 1ps

module fat32_dir_entry_decoder_checker import fatdir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              show_hidden,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              entry_start,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [BYTE_W-1:0] name_char,
	input  logic              char_last,
	input  logic              end_of_dir,
	input  logic              is_directory,
	input  logic [31:0]       first_cluster,
	input  logic [31:0]       file_size,
	input  logic [BYTE_W-1:0] attributes,
	output int                pending,
	output int                predicted,
	output int                errors
);

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              last;
		logic              eod;
		logic              dir;
		logic [31:0]       cluster;
		logic [31:0]       size;
		logic [BYTE_W-1:0] attr;
	} dir_char_t;

	dir_char_t         char_q [$];
	logic [POS_W-1:0]  pos;
	logic [BYTE_W-1:0] name_bytes [NAME_LEN];
	logic [BYTE_W-1:0] attr_byte;
	logic [1:0]        lower_flags;
	logic [31:0]       cluster;
	logic [23:0]       size_low;
	logic              keep_hidden;
	int                fail_cnt = 0;
	int                char_cnt = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		fail_cnt++;
	endtask

	function automatic logic [BYTE_W-1:0] lower_char(input logic [BYTE_W-1:0] c,
		input logic en);
		if (en && c > CHAR_UPPER_LO && c < CHAR_UPPER_HI) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

	task automatic push_char(input logic [BYTE_W-1:0] ch, input logic last, input logic eod,
		input logic dir, input logic [31:0] clus, input logic [31:0] size,
		input logic [BYTE_W-1:0] attr);
		dir_char_t r;
		r.ch = ch;
		r.last = last;
		r.eod = eod;
		r.dir = dir;
		r.cluster = clus;
		r.size = size;
		r.attr = attr;
		char_q.push_back(r);
		char_cnt++;
	endtask

	task automatic close_entry(input logic [BYTE_W-1:0] last_byte);
		logic [31:0]       size;
		logic              dir;
		int                base_end;
		int                ext_end;
		int                n;
		logic [BYTE_W-1:0] chars [MAX_CHARS];
		size = {last_byte, size_low};
		if (name_bytes[0] == CHAR_ZERO) begin
			push_char(CHAR_ZERO, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, '0);
			return;
		end
		if (name_bytes[0] == CHAR_DELETED || attr_byte[3:0] == ATTR_LFN_NIBBLE ||
			attr_byte[ATTR_VOLUME_BIT] || (attr_byte[ATTR_HIDDEN_BIT] && !keep_hidden)) begin
			return;
		end
		dir = attr_byte[ATTR_DIR_BIT];
		// A blank base name still yields its first byte.
		base_end = 0;
		for (int i = 0; i < BASE_LEN; i++) begin
			if (name_bytes[i] != CHAR_SPACE) base_end = i;
		end
		n = 0;
		for (int i = 0; i <= base_end; i++) begin
			chars[n] = lower_char(name_bytes[i], lower_flags[0]);
			n++;
		end
		if (!dir) begin
			ext_end = -1;
			for (int i = BASE_LEN; i < NAME_LEN; i++) begin
				if (name_bytes[i] != CHAR_SPACE) ext_end = i;
			end
			if (ext_end >= 0) begin
				chars[n] = CHAR_DOT;
				n++;
				for (int i = BASE_LEN; i <= ext_end; i++) begin
					chars[n] = lower_char(name_bytes[i], lower_flags[1]);
					n++;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			push_char(chars[k], k == n - 1, 1'b0, dir, cluster, size, attr_byte);
		end
	endtask

	task automatic take_byte(input logic [BYTE_W-1:0] b, input logic st);
		if (st) pos = '0;
		case (pos)
			POS_ATTR:     attr_byte = b;
			POS_CASE:     lower_flags = {b[CASE_EXT_SRC_BIT], b[CASE_BASE_SRC_BIT]};
			POS_CLUS_HI0: cluster[23:16] = b;
			POS_CLUS_HI1: cluster[31:24] = b;
			POS_CLUS_LO0: cluster[7:0] = b;
			POS_CLUS_LO1: cluster[15:8] = b;
			POS_SIZE0:    size_low[7:0] = b;
			POS_SIZE1:    size_low[15:8] = b;
			POS_SIZE2:    size_low[23:16] = b;
			POS_LAST:     close_entry(b);
			default: begin
				if (pos <= POS_NAME_LAST) name_bytes[4'(pos)] = b;
			end
		endcase
		pos = pos + 1'b1;
	endtask

	task automatic check_char();
		dir_char_t want;
		if (char_q.size() == 0) begin
			report_mismatch("name_char with nothing expected", 32'(name_char), 32'd0);
			return;
		end
		want = char_q.pop_front();
		if (name_char !== want.ch) begin
			report_mismatch("name_char", 32'(name_char), 32'(want.ch));
		end
		if (char_last !== want.last) begin
			report_mismatch("char_last", 32'(char_last), 32'(want.last));
		end
		if (end_of_dir !== want.eod) begin
			report_mismatch("end_of_dir", 32'(end_of_dir), 32'(want.eod));
		end
		if (is_directory !== want.dir) begin
			report_mismatch("is_directory", 32'(is_directory), 32'(want.dir));
		end
		if (first_cluster !== want.cluster) begin
			report_mismatch("first_cluster", first_cluster, want.cluster);
		end
		if (file_size !== want.size) report_mismatch("file_size", file_size, want.size);
		if (attributes !== want.attr) begin
			report_mismatch("attributes", 32'(attributes), 32'(want.attr));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos = '0;
			keep_hidden = 1'b0;
			char_q.delete();
			pending <= 0;
			predicted <= char_cnt;
			errors <= fail_cnt;
		end else begin
			// The first character of an entry cannot leave in the cycle its last byte arrives,
			// so checking before predicting keeps the queue order right.
			if (out_valid && out_ready) check_char();
			if (in_valid && in_ready) take_byte(data_byte, entry_start);
			// A register write applies to bytes taken after this edge.
			if (cfg_valid && cfg_ready) keep_hidden = show_hidden;
			pending <= char_q.size();
			predicted <= char_cnt;
			errors <= fail_cnt;
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for the FAT32 directory entry decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import fatdir_pkg::*;

	localparam logic [7:0] ATTR_NONE     = 8'h00;
	localparam logic [7:0] ATTR_READONLY = 8'h01;
	localparam logic [7:0] ATTR_HIDDEN   = 8'h02;
	localparam logic [7:0] ATTR_DIR      = 8'h10;
	localparam logic [7:0] ATTR_ARCHIVE  = 8'h20;
	localparam logic [7:0] CASE_UPPER    = 8'h00;
	localparam logic [7:0] CASE_ALL_LOW  = 8'h18;
	localparam int         RANDOM_BYTES  = 160;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              show_hidden = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              entry_start = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] name_char;
	logic              char_last;
	logic              end_of_dir;
	logic              is_directory;
	logic [31:0]       first_cluster;
	logic [31:0]       file_size;
	logic [BYTE_W-1:0] attributes;
	int                pending;
	int                predicted;
	int                errors;

	logic [BYTE_W-1:0] ent [32];
	logic              calm = 1'b0;
	int                bytes_sent = 0;
	int                entries_sent = 0;
	int                listing_writes = 0;
	int                lookup_writes = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fat32_dir_entry_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.show_hidden   (show_hidden),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.entry_start   (entry_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.name_char     (name_char),
		.char_last     (char_last),
		.end_of_dir    (end_of_dir),
		.is_directory  (is_directory),
		.first_cluster (first_cluster),
		.file_size     (file_size),
		.attributes    (attributes)
	);

	fat32_dir_entry_decoder_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.show_hidden   (show_hidden),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.entry_start   (entry_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.name_char     (name_char),
		.char_last     (char_last),
		.end_of_dir    (end_of_dir),
		.is_directory  (is_directory),
		.first_cluster (first_cluster),
		.file_size     (file_size),
		.attributes    (attributes),
		.pending       (pending),
		.predicted     (predicted),
		.errors        (errors)
	);

	initial begin
		#5_000_000;
		$display("timeout with %0d characters still expected", pending);
		$display("status: fail");
		$finish;
	end

	// Result side: a random stall before each request, none while calm is set.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		entry_start <= st;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_entry(input logic st);
		for (int i = 0; i < 32; i++) begin
			send_byte(ent[i], (i == 0) ? st : 1'b0);
		end
		entries_sent++;
	endtask

	task automatic make_entry(input string nm, input logic [7:0] attr,
		input logic [7:0] case_byte, input logic [31:0] clus, input logic [31:0] size);
		for (int i = 0; i < 32; i++) begin
			ent[i] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < NAME_LEN; i++) begin
			ent[i] = nm[i];
		end
		ent[POS_ATTR] = attr;
		ent[POS_CASE] = case_byte;
		ent[POS_CLUS_HI0] = clus[23:16];
		ent[POS_CLUS_HI1] = clus[31:24];
		ent[POS_CLUS_LO0] = clus[7:0];
		ent[POS_CLUS_LO1] = clus[15:8];
		ent[POS_SIZE0] = size[7:0];
		ent[POS_SIZE1] = size[15:8];
		ent[POS_SIZE2] = size[23:16];
		ent[POS_LAST] = size[31:24];
	endtask

	function automatic logic [7:0] pick_name_byte();
		case ($urandom_range(0, 7))
			0: return CHAR_SPACE;
			1: return 8'($urandom_range(0, 255));
			2: return 8'(8'h61 + $urandom_range(0, 25));
			default: return 8'(8'h41 + $urandom_range(0, 25));
		endcase
	endfunction

	// Well-formed entry with random content; most are visible, a few are skipped kinds.
	task automatic rand_entry();
		int         base_len;
		int         ext_len;
		logic [7:0] attr;
		for (int i = 0; i < 32; i++) begin
			ent[i] = 8'($urandom_range(0, 255));
		end
		base_len = $urandom_range(1, BASE_LEN);
		ext_len = $urandom_range(0, EXT_LEN);
		for (int i = 0; i < BASE_LEN; i++) begin
			ent[i] = (i < base_len) ? pick_name_byte() : CHAR_SPACE;
		end
		for (int i = 0; i < EXT_LEN; i++) begin
			ent[BASE_LEN + i] = (i < ext_len) ? pick_name_byte() : CHAR_SPACE;
		end
		case ($urandom_range(0, 19))
			0: ent[0] = CHAR_DELETED;
			1: ent[0] = CHAR_ZERO;
			default: ;
		endcase
		attr = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) != 0) begin
			attr[ATTR_VOLUME_BIT] = 1'b0;
			if ($urandom_range(0, 1) != 0) attr[ATTR_HIDDEN_BIT] = 1'b0;
		end
		ent[POS_ATTR] = attr;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		// Skipped entries give no result, so leave room for one still in flight.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		cfg_valid <= 1'b1;
		show_hidden <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v) lookup_writes++;
		else listing_writes++;
	endtask

	initial begin
		int start_bytes;
		int iter;
		int phase;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(1'b0);

		make_entry("@AZ[az  _Z{", ATTR_READONLY, CASE_ALL_LOW, 32'h0001_0000, 32'h0000_0100);
		send_entry(1'b1);
		// Directory with extension bytes; no entry_start, so the position must wrap.
		make_entry("SUBDIR  ABC", ATTR_DIR, CASE_ALL_LOW, 32'h0012_3456, 32'h0);
		send_entry(1'b0);
		make_entry("        EXE", ATTR_NONE, CASE_UPPER, 32'h0000_0003, 32'h0000_0001);
		send_entry(1'b0);
		make_entry("SECRET  DAT", ATTR_HIDDEN, CASE_UPPER, 32'h0000_0006, 32'h0000_0040);
		send_entry(1'b1);
		make_entry("ENDMARK    ", ATTR_ARCHIVE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		ent[0] = CHAR_ZERO;
		send_entry(1'b0);

		drain();
		write_cfg(1'b1);
		make_entry("SECRET  DAT", ATTR_HIDDEN, CASE_ALL_LOW, 32'h0000_0006, 32'h0000_0040);
		send_entry(1'b1);
		drain();

		// Random part: short phases, each with its own show_hidden setting.
		start_bytes = bytes_sent;
		iter = 0;
		phase = 1;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			if (iter % 2 == 0) begin
				drain();
				phase++;
				write_cfg(phase[0]);
				calm <= (phase % 4 == 2);
			end
			case ($urandom_range(0, 9))
				0: begin
					k = $urandom_range(1, 40);
					for (int i = 0; i < k; i++) begin
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
					end
				end
				1: begin
					rand_entry();
					k = $urandom_range(1, 31);
					for (int i = 0; i < k; i++) begin
						send_byte(ent[i], i == 0);
					end
					rand_entry();
					send_entry(1'b1);
				end
				default: begin
					rand_entry();
					send_entry($urandom_range(0, 3) != 0);
				end
			endcase
			iter++;
		end

		in_valid <= 1'b0;
		calm <= 1'b0;
		k = 0;
		do begin
			@(posedge clk);
			k++;
		end while (pending != 0 && k < 20000);
		repeat (20) @(posedge clk);
		$display("sent %0d bytes (%0d framed entries), %0d name characters predicted",
			bytes_sent, entries_sent, predicted);
		$display("listing mode set %0d times, lookup mode set %0d times, %0d mismatches",
			listing_writes, lookup_writes, errors);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ fat32_dir_entry_decoder_unit.f @@
+incdir+hw/rtl
hw/rtl/fatdir_pkg.sv
hw/rtl/fatdir_name_fmt.sv
hw/rtl/fat32_dir_entry_decoder_unit.sv
sim/fat32_dir_entry_decoder_checker.sv
sim/tb.sv
